// File: hw/rtl/saa_pkg.sv
// Package for the shelf atlas allocator: atlas and row table sizes,
// payload structs and the row table entry layout.
// No dependencies.
package saa_pkg;

  localparam int unsigned ATLAS_SIZE = 1024;
  localparam int unsigned MAX_ROWS   = 64;

  // Coordinate fields are fixed at 11 bits by the interface.
  localparam int unsigned COORD_W   = 11;
  localparam int unsigned ROW_IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned ROW_CNT_W = $clog2(MAX_ROWS + 1);

  localparam logic [COORD_W-1:0] AtlasC = COORD_W'(ATLAS_SIZE);

  typedef struct packed {
    logic [COORD_W-1:0] rect_width;
    logic [COORD_W-1:0] rect_height;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] x_offset;
    logic [COORD_W-1:0] y_offset;
    logic               placed;
  } out_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] height;
    logic [COORD_W-1:0] free_width;
  } row_t;

  localparam int unsigned ROW_W = $bits(row_t);

endpackage

// File: hw/rtl/saa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module saa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: hw/rtl/shelf_atlas_allocator_core.sv
// Shelf atlas allocator top level; depends on saa_pkg and saa_ram.
// From accept, the sequencer steps through the scan (one row read per table row), a last
// check step and a decide step that registers the result; with no rows or an oversized
// width it goes straight to decide. One item at a time: the next is accepted after the result issues.
// The scan reads one row per cycle; a result still waiting holds the decide step.
// Reset (rst_ni low, asynchronous): no rows, full free height, nothing growable.
module shelf_atlas_allocator_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  saa_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output saa_pkg::out_item_t out_item_o
);
  import saa_pkg::*;

  // Sequencer codes
  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StLast   = 2'd2;
  localparam logic [1:0] StDecide = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [ROW_CNT_W-1:0] row_cnt_q, row_cnt_d;
  logic [COORD_W-1:0]   free_h_q, free_h_d;
  logic                 growable_q, growable_d;

  // Request held for the whole search
  logic [COORD_W-1:0]   req_w_q, req_h_q;
  logic                 fail_q, fail_d;

  // Scan pointers: read address issued, and row whose data is arriving
  logic [ROW_IDX_W-1:0] idx_q, idx_d;
  logic [ROW_IDX_W-1:0] chk_idx_q, chk_idx_d;
  logic                 chk_valid_q, chk_valid_d;

  // Best row so far (the last fitting one wins)
  logic                 found_q, found_d;
  logic                 grow_q, grow_d;
  logic [ROW_IDX_W-1:0] pick_idx_q, pick_idx_d;
  row_t                 pick_row_q, pick_row_d;

  out_item_t            out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  // Row table port
  logic                 ram_we, ram_re;
  logic [ROW_IDX_W-1:0] ram_waddr;
  row_t                 ram_wdata, ram_rdata;

  saa_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_ROWS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // Row check on the data coming back from the table
  logic               fits_w, tall_enough, newest, can_grow, hit;
  logic [COORD_W-1:0] h_diff;

  always_comb begin
    fits_w      = ram_rdata.free_width >= req_w_q;
    tall_enough = ram_rdata.height >= req_h_q;
    h_diff      = req_h_q - ram_rdata.height;
    newest      = ((ROW_CNT_W'(chk_idx_q) + ROW_CNT_W'(1)) == row_cnt_q) && growable_q;
    can_grow    = newest && (free_h_q >= h_diff);
    hit         = chk_valid_q && fits_w && (tall_enough || can_grow);
  end

  // Decision step
  logic out_free;
  logic last_issue;
  logic [COORD_W-1:0] grow_diff;

  assign out_free   = !out_valid_q || out_ready_i;
  assign last_issue = (ROW_CNT_W'(idx_q) + ROW_CNT_W'(1)) == row_cnt_q;
  assign grow_diff  = req_h_q - pick_row_q.height;

  always_comb begin
    state_d     = state_q;
    row_cnt_d   = row_cnt_q;
    free_h_d    = free_h_q;
    growable_d  = growable_q;
    fail_d      = fail_q;
    idx_d       = idx_q;
    chk_idx_d   = chk_idx_q;
    chk_valid_d = 1'b0;
    found_d     = found_q;
    grow_d      = grow_q;
    pick_idx_d  = pick_idx_q;
    pick_row_d  = pick_row_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = pick_idx_q;
    ram_wdata   = pick_row_q;
    in_ready_o  = (state_q == StIdle);

    // Drop the result once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // Keep the last fitting row seen
    if (hit) begin
      found_d    = 1'b1;
      grow_d     = !tall_enough;
      pick_idx_d = chk_idx_q;
      pick_row_d = ram_rdata;
    end

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          fail_d  = in_item_i.rect_width > AtlasC;
          found_d = 1'b0;
          grow_d  = 1'b0;
          idx_d   = '0;
          if ((in_item_i.rect_width > AtlasC) || (row_cnt_q == '0)) begin
            state_d = StDecide;
          end else begin
            state_d = StScan;
          end
        end
      end
      StScan: begin
        // Issue one row read per cycle
        ram_re      = 1'b1;
        chk_valid_d = 1'b1;
        chk_idx_d   = idx_q;
        idx_d       = idx_q + ROW_IDX_W'(1);
        if (last_issue) begin
          state_d = StLast;
        end
      end
      StLast: begin
        // Last row's data is checked this cycle
        state_d = StDecide;
      end
      StDecide: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          state_d     = StIdle;
          if (fail_q) begin
            out_d = '0;
          end else if (found_q) begin
            ram_we               = 1'b1;
            ram_waddr            = pick_idx_q;
            ram_wdata            = pick_row_q;
            ram_wdata.free_width = pick_row_q.free_width - req_w_q;
            if (grow_q) begin
              ram_wdata.height = req_h_q;
              free_h_d         = free_h_q - grow_diff;
            end
            out_d.x_offset = AtlasC - pick_row_q.free_width;
            out_d.y_offset = pick_row_q.top;
            out_d.placed   = 1'b1;
          end else if ((free_h_q < req_h_q) || (row_cnt_q >= ROW_CNT_W'(MAX_ROWS))) begin
            out_d = '0;
          end else begin
            // Open a new shelf at the top of the free height
            ram_we               = 1'b1;
            ram_waddr            = row_cnt_q[ROW_IDX_W-1:0];
            ram_wdata.top        = AtlasC - free_h_q;
            ram_wdata.height     = req_h_q;
            ram_wdata.free_width = AtlasC - req_w_q;
            row_cnt_d            = row_cnt_q + ROW_CNT_W'(1);
            growable_d           = 1'b1;
            free_h_d             = free_h_q - req_h_q;
            out_d.x_offset       = '0;
            out_d.y_offset       = AtlasC - free_h_q;
            out_d.placed         = 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      row_cnt_q   <= '0;
      free_h_q    <= AtlasC;
      growable_q  <= 1'b0;
      chk_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_cnt_q   <= row_cnt_d;
      free_h_q    <= free_h_d;
      growable_q  <= growable_d;
      chk_valid_q <= chk_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and search registers: no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_w_q <= in_item_i.rect_width;
      req_h_q <= in_item_i.rect_height;
    end
    fail_q     <= fail_d;
    idx_q      <= idx_d;
    chk_idx_q  <= chk_idx_d;
    found_q    <= found_d;
    grow_q     <= grow_d;
    pick_idx_q <= pick_idx_d;
    pick_row_q <= pick_row_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Checks on the allocator's own bookkeeping
  a_row_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_cnt_q <= ROW_CNT_W'(MAX_ROWS))
    else $error("row count beyond table depth");

  a_free_h_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_h_q <= AtlasC)
    else $error("free height beyond atlas size");

  a_row_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_cnt_q != $past(row_cnt_q)) |-> (row_cnt_q == $past(row_cnt_q) + ROW_CNT_W'(1)))
    else $error("row count moved by more than one");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.placed) |->
      ((out_item_o.x_offset == '0) && (out_item_o.y_offset == '0)))
    else $error("failed placement with non-zero offsets");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready held high after accepting an item");

endmodule

// File: tb/shelf_atlas_allocator_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for shelf_atlas_allocator_core: directed and random
// rectangle requests, scored against an in-bench shelf packing predictor.
// Depends on saa_pkg and the allocator RTL.
module shelf_atlas_allocator_core_tb;
  import saa_pkg::*;

  localparam int unsigned RAND_ITEMS = 800;
  localparam int unsigned HOLD_AFTER = 150;   // results seen before the long hold-off
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_AT = 400;     // random item at which the sender drains
  localparam int unsigned SETTLE_CYCLES = MAX_ROWS + 8;
  localparam int unsigned PRINT_CAP = 40;
  localparam longint unsigned LIMIT_NS = 6_000_000;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  shelf_atlas_allocator_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // 12 ns clock, high then low.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shelf packing predictor. Its own copy of the row table, free height and
  // the growable flag of the newest row; only rows below shelf_count are read.
  // ---------------------------------------------------------------------------
  int unsigned shelf_top    [MAX_ROWS];
  int unsigned shelf_height [MAX_ROWS];
  int unsigned shelf_free   [MAX_ROWS];
  int unsigned shelf_count = 0;
  int unsigned atlas_free_height = ATLAS_SIZE;
  bit          newest_growable = 1'b0;

  // Placements still owed by the block, oldest first.
  out_item_t   placement_q [$];
  int unsigned fail_count = 0;
  int unsigned results_done = 0;

  // Work out where a request lands and update the shelf state. A failed
  // request leaves every piece of state untouched and yields all zeros.
  function automatic out_item_t place_rect(input in_item_t req);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned pick;
    int unsigned x;
    int unsigned y;
    bit          hit;
    bit          grow;
    out_item_t   res;
    w    = req.rect_width;
    h    = req.rect_height;
    res  = '0;
    pick = 0;
    hit  = 1'b0;
    grow = 1'b0;
    if (w > ATLAS_SIZE) return res;
    // Scan every open row; the last one that fits wins.
    for (r = 0; r < shelf_count; r++) begin
      if (shelf_free[r] < w) continue;
      if (shelf_height[r] < h) begin
        // A low row only counts if it is the newest, still growable, and the
        // remaining height covers the difference.
        if (r + 1 == shelf_count && newest_growable &&
            atlas_free_height >= h - shelf_height[r]) begin
          pick = r;
          hit  = 1'b1;
          grow = 1'b1;
        end
      end else begin
        pick = r;
        hit  = 1'b1;
        grow = 1'b0;
      end
    end
    if (hit) begin
      if (grow) begin
        atlas_free_height -= h - shelf_height[pick];
        shelf_height[pick] = h;
      end
    end else begin
      // Open a new row at the top of the free height, if there is room for it.
      if (atlas_free_height < h || shelf_count >= MAX_ROWS) return res;
      pick               = shelf_count;
      shelf_top[pick]    = ATLAS_SIZE - atlas_free_height;
      shelf_height[pick] = h;
      shelf_free[pick]   = ATLAS_SIZE;
      shelf_count++;
      newest_growable    = 1'b1;
      atlas_free_height -= h;
    end
    x = ATLAS_SIZE - shelf_free[pick];
    y = shelf_top[pick];
    shelf_free[pick] -= w;
    res.x_offset = x[COORD_W-1:0];
    res.y_offset = y[COORD_W-1:0];
    res.placed   = 1'b1;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    fail_count++;
    if (fail_count <= PRINT_CAP)
      $display("%0t ns: mismatch on %s, got %0d, want %0d", $time, what, got, want);
  endtask

  // Offer one request after an idle gap. Valid stays high between back-to-back
  // items; at acceptance, queue the typed-in placement if there is one, else
  // the predicted one. The predictor runs either way to keep its state aligned.
  task automatic offer_rect(input int unsigned w, input int unsigned h,
                            input int unsigned gap, input bit typed,
                            input out_item_t want);
    in_item_t  req;
    out_item_t pred;
    req.rect_width  = w[COORD_W-1:0];
    req.rect_height = h[COORD_W-1:0];
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    pred = place_rect(req);
    placement_q.push_back(typed ? want : pred);
  endtask

  // ---------------------------------------------------------------------------
  // Directed requests. Expected placements are typed in where they follow at a
  // glance from an empty atlas; the remaining rows go to the predictor.
  // ---------------------------------------------------------------------------
  typedef struct {
    int unsigned w;
    int unsigned h;
    bit          typed;
    out_item_t   want;
  } rect_case_t;

  localparam int unsigned N_DIRECTED = 17;

  rect_case_t directed_rows [N_DIRECTED] = '{
    // width just past the atlas: reject, state untouched
    '{1025, 5,    1'b1, '{11'd0, 11'd0, 1'b0}},
    // both fields at all ones
    '{2047, 2047, 1'b1, '{11'd0, 11'd0, 1'b0}},
    // zero by zero opens row 0 with height 0
    '{0,    0,    1'b1, '{11'd0, 11'd0, 1'b1}},
    // full width grows the newest row from 0 to 16
    '{1024, 16,   1'b1, '{11'd0, 11'd0, 1'b1}},
    // row 0 is full, so open row 1 at y = 16
    '{1,    1,    1'b1, '{11'd0, 11'd16, 1'b1}},
    // too tall for growth and for a new row
    '{10,   2047, 1'b1, '{11'd0, 11'd0, 1'b0}},
    // zero width, still too tall: the older row cannot grow
    '{0,    2047, 1'b1, '{11'd0, 11'd0, 1'b0}},
    // zero by zero fits both rows, the last one wins
    '{0,    0,    1'b1, '{11'd1, 11'd16, 1'b1}},
    // height above the free height with no row fitting
    '{8,    1024, 1'b1, '{11'd0, 11'd0, 1'b0}},
    '{100,  8,    1'b0, '0},
    '{923,  4,    1'b0, '0},
    '{1,    4,    1'b0, '0},
    '{5,    30,   1'b0, '0},
    '{1024, 0,    1'b0, '0},
    '{0,    5,    1'b0, '0},
    '{513,  2,    1'b0, '0},
    // full atlas square no longer fits anywhere
    '{1024, 1024, 1'b1, '{11'd0, 11'd0, 1'b0}}
  };

  // ---------------------------------------------------------------------------
  // Result side: ready with random stalls, zero-stall stretches, and one long
  // hold-off so the block backs up and drops in_ready_o.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    bit          held;
    held = 1'b0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!held && results_done >= HOLD_AFTER) begin
        stall = HOLD_CYCLES;
        held  = 1'b1;
      end else if ((results_done / 50) % 4 == 2) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 18);
      end
      repeat (stall) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // Score every accepted result against the oldest placement owed.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_done++;
      if (placement_q.size() == 0) begin
        report_mismatch("result with nothing pending (x_offset)", out_item_o.x_offset, 0);
      end else begin
        want = placement_q.pop_front();
        if (out_item_o.x_offset !== want.x_offset)
          report_mismatch("x_offset", out_item_o.x_offset, want.x_offset);
        if (out_item_o.y_offset !== want.y_offset)
          report_mismatch("y_offset", out_item_o.y_offset, want.y_offset);
        if (out_item_o.placed !== want.placed)
          report_mismatch("placed", out_item_o.placed, want.placed);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side: reset, directed rows, then random requests whose sizes widen
  // as the run goes on so that rows close, the table fills and height runs out.
  // ---------------------------------------------------------------------------
  initial begin : request_source
    int unsigned i;
    int unsigned w;
    int unsigned h;
    int unsigned gap;
    int unsigned roll;
    int unsigned wmax;
    int unsigned hmax;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (i = 0; i < N_DIRECTED; i++) begin
      gap = $urandom_range(0, 18);
      offer_rect(directed_rows[i].w, directed_rows[i].h, gap,
                 directed_rows[i].typed, directed_rows[i].want);
    end

    for (i = 0; i < RAND_ITEMS; i++) begin
      // Hold the sender back once until the block has returned everything.
      if (i == DRAIN_AT) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        while (placement_q.size() != 0) @(posedge clk_i);
      end
      wmax = (64 + i > ATLAS_SIZE) ? ATLAS_SIZE : 64 + i;
      hmax = 4 + i / 40;
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        // oversized width: always rejected
        w = $urandom_range(ATLAS_SIZE + 1, 2047);
        h = $urandom_range(0, 2047);
      end else if (roll < 8) begin
        // height beyond the atlas: can never fit
        w = $urandom_range(0, 2047);
        h = $urandom_range(ATLAS_SIZE + 1, 2047);
      end else if (roll < 12) begin
        // field extremes
        w = $urandom_range(0, 1) ? ATLAS_SIZE : 0;
        h = $urandom_range(0, 1) ? 0 : $urandom_range(0, hmax);
      end else begin
        w = $urandom_range(0, wmax);
        h = $urandom_range(0, hmax);
      end
      gap = ((i / 50) % 4 == 1) ? 0 : $urandom_range(0, 18);
      offer_rect(w, h, gap, 1'b0, '0);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Drain, then let a full scan's worth of cycles pass to catch strays.
    while (placement_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #(LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/saa_pkg.sv
hw/rtl/saa_ram.sv
hw/rtl/shelf_atlas_allocator_core.sv
tb/shelf_atlas_allocator_core_tb.sv
